@@ design/modular_exponentiation_defines.svh @@
// Assertion macros used by the modular exponentiation controller.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Checked at every rising clock edge while reset is released.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/mexp_pkg.sv @@
// Package with shared constants and types of the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned EXP_WIDTH_DEF  = 32;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_SQUARE,
    CMD_MULT,
    CMD_STEP,
    CMD_WRITEBACK,
    CMD_NEXT_BIT
  } mexp_cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic exp_msb;
    logic mul_done;
  } mexp_status_t;

  // Command word; the output register load travels with it.
  typedef struct packed {
    mexp_cmd_e op;
    logic      out_load;
  } mexp_ctrl_t;

endpackage

@@ design/mexp_datapath.sv @@
// Datapath: modulus register, base reduction and shift-add modular multiplier.
`timescale 1ns / 1ps
module mexp_datapath #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned EXP_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  input  logic [DATA_WIDTH-1:0] base_i,
  input  logic [EXP_WIDTH-1:0]  exponent_i,
  input  mexp_pkg::mexp_ctrl_t  ctrl_i,
  output mexp_pkg::mexp_status_t status_o,
  output logic [DATA_WIDTH-1:0] power_mod_o
);
  import mexp_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0]         m_q;
  logic [W-1:0]         base_q, base_d;
  logic [W-1:0]         rem_q, rem_d;
  logic [W-1:0]         r_q, r_d;
  logic [W-1:0]         mx_q, mx_d;
  logic [W-1:0]         my_q, my_d;
  logic [W-1:0]         macc_q, macc_d;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [W-1:0]         out_q;
  logic [W:0]           rem_shift;

  // (x + y) mod m for x and y already below m.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[W-1:0];
  endfunction

  assign rem_shift = {rem_q, base_q[W-1]};

  always_comb begin
    base_d = base_q;
    rem_d  = rem_q;
    r_d    = r_q;
    mx_d   = mx_q;
    my_d   = my_q;
    macc_d = macc_q;
    exp_d  = exp_q;
    case (ctrl_i.op)
      CMD_LOAD: begin
        base_d = base_i;
        exp_d  = exponent_i;
        rem_d  = '0;
        // A zero exponent gives one unreduced; otherwise the start value is 1 mod m.
        if (exponent_i == '0 || m_q[W-1:1] != '0) begin
          r_d = W'(1);
        end else begin
          r_d = '0;
        end
      end
      CMD_REDUCE: begin
        base_d = {base_q[W-2:0], 1'b0};
        if (rem_shift >= {1'b0, m_q}) begin
          rem_d = W'(rem_shift - {1'b0, m_q});
        end else begin
          rem_d = rem_shift[W-1:0];
        end
      end
      CMD_SQUARE: begin
        mx_d   = r_q;
        my_d   = r_q;
        macc_d = '0;
      end
      CMD_MULT: begin
        mx_d   = r_q;
        my_d   = rem_q;
        macc_d = '0;
      end
      CMD_STEP: begin
        if (my_q[0]) begin
          macc_d = add_mod(macc_q, mx_q, m_q);
        end
        mx_d = add_mod(mx_q, mx_q, m_q);
        my_d = {1'b0, my_q[W-1:1]};
      end
      CMD_WRITEBACK: begin
        r_d = macc_q;
      end
      CMD_NEXT_BIT: begin
        exp_d = exp_q << 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= W'(1);
    end else if (cfg_valid_i) begin
      m_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
    r_q    <= r_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    macc_q <= macc_d;
    exp_q  <= exp_d;
    if (ctrl_i.out_load) begin
      out_q <= r_q;
    end
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.mod_zero = (m_q == '0);
  assign status_o.exp_msb  = exp_q[EXP_WIDTH-1];
  assign status_o.mul_done = (my_q == '0);
  assign power_mod_o       = out_q;

endmodule

@@ design/mexp_ctrl.sv @@
// Controller: sequences reduction, squarings and multiplications per exponent bit.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"
module mexp_ctrl #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned EXP_WIDTH  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  mexp_pkg::mexp_status_t status_i,
  output mexp_pkg::mexp_ctrl_t   ctrl_o
);
  import mexp_pkg::*;

  localparam int unsigned RCW = $clog2(DATA_WIDTH);
  localparam int unsigned BCW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_SQ_START,
    ST_MSTEP,
    ST_MUL_START,
    ST_BIT_END,
    ST_FINISH
  } state_e;

  state_e         state_q, state_d;
  logic [RCW-1:0] red_cnt_q, red_cnt_d;
  logic [BCW-1:0] bit_cnt_q, bit_cnt_d;
  logic           is_sq_q, is_sq_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    red_cnt_d   = red_cnt_q;
    bit_cnt_d   = bit_cnt_q;
    is_sq_d     = is_sq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl_o.op       = CMD_NONE;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = CMD_LOAD;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        red_cnt_d = '0;
        if (status_i.exp_zero || status_i.mod_zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ctrl_o.op = CMD_REDUCE;
        red_cnt_d = red_cnt_q + RCW'(1);
        if (red_cnt_q == RCW'(DATA_WIDTH - 1)) begin
          bit_cnt_d = '0;
          state_d   = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        ctrl_o.op = CMD_SQUARE;
        is_sq_d   = 1'b1;
        state_d   = ST_MSTEP;
      end
      ST_MSTEP: begin
        if (status_i.mul_done) begin
          ctrl_o.op = CMD_WRITEBACK;
          if (is_sq_q && status_i.exp_msb) begin
            state_d = ST_MUL_START;
          end else begin
            state_d = ST_BIT_END;
          end
        end else begin
          ctrl_o.op = CMD_STEP;
        end
      end
      ST_MUL_START: begin
        ctrl_o.op = CMD_MULT;
        is_sq_d   = 1'b0;
        state_d   = ST_MSTEP;
      end
      ST_BIT_END: begin
        ctrl_o.op = CMD_NEXT_BIT;
        bit_cnt_d = bit_cnt_q + BCW'(1);
        if (bit_cnt_q == BCW'(EXP_WIDTH - 1)) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SQ_START;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      red_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      is_sq_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      is_sq_q     <= is_sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `MEXP_ASSERT(a_one_request_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "second request taken while busy")
  `MEXP_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result raised outside finish")
  `MEXP_ASSERT(a_no_overwrite, state_q == ST_FINISH && out_valid_q && !out_ready_i |=> state_q == ST_FINISH, "pending result overwritten")

endmodule

@@ design/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: ports, packing and the two submodules.
//
// Usage: write the modulus on the configuration channel (cfg_valid_i with
// cfg_data_i; cfg_ready_o is always high) while the block is idle. Each request
// on the slave stream carries a base and an exponent in s_axis_tdata; the block
// returns one result per request, base to the power exponent modulo the
// modulus, on the master stream. A zero exponent returns one.
// The base is first reduced modulo the modulus by a restoring
// shift-subtract over its DATA_WIDTH bits. Every exponent bit then costs one
// squaring and, for a set bit, one multiplication, each with a setup step, one
// shift-add step per significant bit of its multiplier and a write-back, and a
// final step closes the bit. A check state comes before the reduction and a
// hand-off state after the last bit; a zero exponent or modulus goes from the
// check straight to the hand-off. One request is processed at a time; the
// next one is taken once the previous result has moved to the output register.
// Reset clears the controller and sets the modulus to one. When the receiver
// stalls, the finished result waits in the output register while the next
// request is taken and processed; that one holds in its final state until the
// output register frees up.
`timescale 1ns / 1ps
module modular_exponentiation #(
  parameter int unsigned DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF,
  parameter int unsigned EXP_WIDTH  = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Configuration write channel: modulus.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  // Request stream.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0 up: base, exponent, zero fill.
  input  logic [((DATA_WIDTH+EXP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Result stream.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0 up: power_mod, zero fill.
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import mexp_pkg::*;

  localparam int unsigned OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  mexp_ctrl_t            ctrl;
  mexp_status_t          status;
  logic [DATA_WIDTH-1:0] power_mod;

  // The modulus register is not guarded: the user must write it only while idle; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  mexp_ctrl #(
    .DATA_WIDTH(DATA_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mexp_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .base_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .exponent_i (s_axis_tdata[DATA_WIDTH+EXP_WIDTH-1:DATA_WIDTH]),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .power_mod_o(power_mod)
  );

  assign m_axis_tdata = OUT_W'(power_mod);

endmodule
